FILE: rtl/figs_pkg.sv
// ----------------------------------------------------------------------------
// figs_pkg
// Shared types, register codes, class weights and the triangle setup
// function for the fuzzy integral gain scheduler.
// ----------------------------------------------------------------------------
package figs_pkg;

	localparam int BP_W          = 24;
	localparam int DIFF_W        = 26;
	localparam int CFG_IDX_W     = 4;
	localparam int GAIN_W        = 16;
	localparam int W_W           = 16;
	localparam int SHOULDER_SPAN = 25600;

	typedef struct packed {
		logic signed [BP_W-1:0] err_value;
		logic signed [BP_W-1:0] err_change;
	} figs_in_t;

	typedef struct packed {
		logic [GAIN_W-1:0] ki_gain;
		logic              no_rule_fired;
	} figs_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ERR_NL = 4'd0,
		REG_ERR_NS = 4'd1,
		REG_ERR_PS = 4'd2,
		REG_ERR_PL = 4'd3,
		REG_CHG_NL = 4'd4,
		REG_CHG_NS = 4'd5,
		REG_CHG_PS = 4'd6,
		REG_CHG_PL = 4'd7
	} cfg_reg_t;

	localparam logic signed [BP_W-1:0] RST_NL = -24'sd51200;
	localparam logic signed [BP_W-1:0] RST_NS = -24'sd25600;
	localparam logic signed [BP_W-1:0] RST_PS = 24'sd25600;
	localparam logic signed [BP_W-1:0] RST_PL = 24'sd51200;

	// Q4.12 class weights
	localparam logic [W_W-1:0] W_PM  = 16'd38491;
	localparam logic [W_W-1:0] W_PMS = 16'd36451;
	localparam logic [W_W-1:0] W_PS  = 16'd32811;
	localparam logic [W_W-1:0] W_PVS = 16'd30113;

	typedef enum logic [1:0] {
		MK_ZERO,
		MK_ONE,
		MK_DIV
	} memb_kind_t;

	typedef struct packed {
		memb_kind_t        kind;
		logic [DIFF_W-1:0] num;
		logic [DIFF_W-1:0] den;
	} tri_prep_t;

	function automatic tri_prep_t tri_prep(
		input logic signed [DIFF_W-1:0] x,
		input logic signed [DIFF_W-1:0] left,
		input logic signed [DIFF_W-1:0] peak,
		input logic signed [DIFF_W-1:0] right
	);
		tri_prep_t p;
		p.kind = MK_ZERO;
		p.num  = '0;
		p.den  = '0;
		if (x == peak) begin
			p.kind = MK_ONE;
		end else if (x < peak) begin
			if (x > left) begin
				p.kind = MK_DIV;
				p.num  = DIFF_W'(x - left);
				p.den  = DIFF_W'(peak - left);
			end
		end else if (x < right) begin
			p.kind = MK_DIV;
			p.num  = DIFF_W'(right - x);
			p.den  = DIFF_W'(right - peak);
		end
		return p;
	endfunction

endpackage

FILE: rtl/figs_fuzz.sv
// ----------------------------------------------------------------------------
// figs_fuzz
// Fuzzifies one input into five memberships: a setup stage followed by a
// bit-per-stage restoring divider for each of the five sets.
// ----------------------------------------------------------------------------
module figs_fuzz
	import figs_pkg::*;
#(
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [BP_W-1:0] x,
	input  logic signed [BP_W-1:0] nl,
	input  logic signed [BP_W-1:0] ns,
	input  logic signed [BP_W-1:0] ps,
	input  logic signed [BP_W-1:0] pl,
	output logic                   out_valid,
	output logic [4:0][F:0]        memb
);

	tri_prep_t prep [5];
	logic signed [DIFF_W-1:0] xs, nls, nss, pss, pls;

	always_comb begin
		xs  = DIFF_W'(x);
		nls = DIFF_W'(nl);
		nss = DIFF_W'(ns);
		pss = DIFF_W'(ps);
		pls = DIFF_W'(pl);
		for (int k = 0; k < 5; k++) begin
			prep[k] = '{kind: MK_ZERO, num: '0, den: '0};
		end
		if (x <= nl) begin
			prep[0].kind = MK_ONE;
		end else if (x <= pl) begin
			prep[0] = tri_prep(xs, nls - DIFF_W'(SHOULDER_SPAN), nls, nss);
			prep[1] = tri_prep(xs, nls, nss, '0);
			prep[2] = tri_prep(xs, nss, '0, pss);
			prep[3] = tri_prep(xs, '0, pss, pls);
			prep[4] = tri_prep(xs, pss, pls, pls + DIFF_W'(SHOULDER_SPAN));
		end else begin
			prep[4].kind = MK_ONE;
		end
	end

	logic                    vld_s  [F+1];
	memb_kind_t              kind_s [F+1][5];
	logic [DIFF_W-1:0]       rem_s  [F+1][5];
	logic [DIFF_W-1:0]       den_s  [F+1][5];
	logic [F-1:0]            quo_s  [F+1][5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 5; k++) begin
			kind_s[0][k] <= prep[k].kind;
			rem_s[0][k]  <= prep[k].num;
			den_s[0][k]  <= prep[k].den;
			quo_s[0][k]  <= '0;
		end
	end

	for (genvar g = 1; g <= F; g++) begin : g_div
		logic [DIFF_W:0]   dbl  [5];
		logic              ge   [5];

		always_comb begin
			for (int k = 0; k < 5; k++) begin
				dbl[k] = {rem_s[g-1][k], 1'b0};
				ge[k]  = dbl[k] >= {1'b0, den_s[g-1][k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int k = 0; k < 5; k++) begin
				kind_s[g][k] <= kind_s[g-1][k];
				den_s[g][k]  <= den_s[g-1][k];
				rem_s[g][k]  <= ge[k] ? DIFF_W'(dbl[k] - {1'b0, den_s[g-1][k]})
				                      : DIFF_W'(dbl[k]);
				quo_s[g][k]  <= {quo_s[g-1][k][F-2:0], ge[k]};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			unique case (kind_s[F][k])
				MK_ONE:  memb[k] = (F+1)'(1) << F;
				MK_DIV:  memb[k] = {1'b0, quo_s[F][k]};
				default: memb[k] = '0;
			endcase
		end
	end

	assign out_valid = vld_s[F];

endmodule

FILE: rtl/figs_rule_agg.sv
// ----------------------------------------------------------------------------
// figs_rule_agg
// Min/max rule evaluation into four classes, weighting and summing into the
// rounded dividend and the membership sum.
// ----------------------------------------------------------------------------
module figs_rule_agg
	import figs_pkg::*;
#(
	parameter int F = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [4:0][F:0]   me,
	input  logic [4:0][F:0]   mc,
	output logic              out_valid,
	output logic [F+18:0]     dividend,
	output logic [F+2:0]      den,
	output logic              den_zero
);

	localparam logic [W_W-1:0] WEIGHT [4] = '{W_PM, W_PMS, W_PS, W_PVS};

	function automatic logic [F:0] vmax(input logic [F:0] a, input logic [F:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [F:0] vmin(input logic [F:0] a, input logic [F:0] b);
		return (a < b) ? a : b;
	endfunction

	logic [F:0] mc_all, mc_side;
	logic [F:0] agg [4];

	always_comb begin
		mc_side = vmax(vmax(mc[0], mc[1]), vmax(mc[3], mc[4]));
		mc_all  = vmax(mc_side, mc[2]);
		agg[0]  = vmax(vmin(me[0], mc_all), vmin(me[4], mc_all));
		agg[1]  = vmax(vmin(me[1], mc_all), vmin(me[3], mc_all));
		agg[2]  = vmin(me[2], mc_side);
		agg[3]  = vmin(me[2], mc[2]);
	end

	logic          vld_s1, vld_s2, vld_s3;
	logic [F:0]    agg_s1  [4];
	logic [F+16:0] prod_s2 [4];
	logic [F+2:0]  den_s2;
	logic [F+18:0] dvd_s3;
	logic [F+2:0]  den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		agg_s1 <= agg;
		for (int c = 0; c < 4; c++) begin
			prod_s2[c] <= (F+17)'(agg_s1[c]) * (F+17)'(WEIGHT[c]);
		end
		den_s2 <= (F+3)'(agg_s1[0]) + (F+3)'(agg_s1[1]) + (F+3)'(agg_s1[2])
		        + (F+3)'(agg_s1[3]);
		dvd_s3 <= (F+19)'(prod_s2[0]) + (F+19)'(prod_s2[1]) + (F+19)'(prod_s2[2])
		        + (F+19)'(prod_s2[3]) + (F+19)'(den_s2 >> 1);
		den_s3 <= den_s2;
	end

	assign out_valid = vld_s3;
	assign dividend  = dvd_s3;
	assign den       = den_s3;
	assign den_zero  = (den_s3 == '0);

endmodule

FILE: rtl/figs_wavg_div.sv
// ----------------------------------------------------------------------------
// figs_wavg_div
// Pipelined restoring divider for the weighted average, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module figs_wavg_div
	import figs_pkg::*;
#(
	parameter int F = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [F+18:0] dividend,
	input  logic [F+2:0]  den,
	input  logic          den_zero,
	output logic          out_valid,
	output figs_out_t     result
);

	localparam int NW = F + 19;

	logic              vld_s  [GAIN_W];
	logic [NW-1:0]     rem_s  [GAIN_W];
	logic [F+2:0]      den_s  [GAIN_W];
	logic              zero_s [GAIN_W];
	logic [GAIN_W-1:0] quo_s  [GAIN_W];

	for (genvar j = 0; j < GAIN_W; j++) begin : g_stage
		logic              src_vld;
		logic [NW-1:0]     src_rem;
		logic [F+2:0]      src_den;
		logic              src_zero;
		logic [GAIN_W-1:0] src_quo;
		logic [NW-1:0]     dsh;
		logic              ge;

		if (j == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_rem  = dividend;
			assign src_den  = den;
			assign src_zero = den_zero;
			assign src_quo  = '0;
		end else begin : g_next
			assign src_vld  = vld_s[j-1];
			assign src_rem  = rem_s[j-1];
			assign src_den  = den_s[j-1];
			assign src_zero = zero_s[j-1];
			assign src_quo  = quo_s[j-1];
		end

		assign dsh = NW'(src_den) << (GAIN_W - 1 - j);
		assign ge  = src_rem >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= ge ? src_rem - dsh : src_rem;
			den_s[j]  <= src_den;
			zero_s[j] <= src_zero;
			quo_s[j]  <= src_quo | (GAIN_W'(ge) << (GAIN_W - 1 - j));
		end
	end

	assign out_valid            = vld_s[GAIN_W-1];
	assign result.ki_gain       = zero_s[GAIN_W-1] ? '0 : quo_s[GAIN_W-1];
	assign result.no_rule_fired = zero_s[GAIN_W-1];

endmodule

FILE: rtl/fuzzy_integral_gain_scheduler_core.sv
// ----------------------------------------------------------------------------
// fuzzy_integral_gain_scheduler_core
// Fuzzy integral gain scheduler: 5x5 min/max rule base, weighted average.
//
//   channel   signals                               transaction
//   input     start, busy, item                     start && !busy
//   config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//   result    done, result                          done (one cycle)
//
// One transaction per cycle; each result passes through the per-bit membership
// and gain dividers.
// busy stays low and cfg_ready stays high. Reset clears the valid bits and
// loads the default breakpoints. The receiver cannot stall.
// ----------------------------------------------------------------------------
module fuzzy_integral_gain_scheduler_core
	import figs_pkg::*;
#(
	parameter int MEMB_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  figs_in_t               item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BP_W-1:0]        cfg_data,
	output logic                   done,
	output figs_out_t              result
);

	localparam int F   = MEMB_FRAC_BITS;
	localparam int LAT = F + 20;

	logic signed [BP_W-1:0] bp_q [8];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q[3'(REG_ERR_NL)] <= RST_NL;
			bp_q[3'(REG_ERR_NS)] <= RST_NS;
			bp_q[3'(REG_ERR_PS)] <= RST_PS;
			bp_q[3'(REG_ERR_PL)] <= RST_PL;
			bp_q[3'(REG_CHG_NL)] <= RST_NL;
			bp_q[3'(REG_CHG_NS)] <= RST_NS;
			bp_q[3'(REG_CHG_PS)] <= RST_PS;
			bp_q[3'(REG_CHG_PL)] <= RST_PL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ERR_NL: bp_q[3'(REG_ERR_NL)] <= cfg_data;
				REG_ERR_NS: bp_q[3'(REG_ERR_NS)] <= cfg_data;
				REG_ERR_PS: bp_q[3'(REG_ERR_PS)] <= cfg_data;
				REG_ERR_PL: bp_q[3'(REG_ERR_PL)] <= cfg_data;
				REG_CHG_NL: bp_q[3'(REG_CHG_NL)] <= cfg_data;
				REG_CHG_NS: bp_q[3'(REG_CHG_NS)] <= cfg_data;
				REG_CHG_PS: bp_q[3'(REG_CHG_PS)] <= cfg_data;
				REG_CHG_PL: bp_q[3'(REG_CHG_PL)] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic            take;
	logic            err_vld, chg_vld;
	logic [4:0][F:0] me, mc;
	logic            agg_vld;
	logic [F+18:0]   dividend;
	logic [F+2:0]    den;
	logic            den_zero;

	assign take = start && !busy;

	figs_fuzz #(.F(F)) u_fuzz_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.x         (item.err_value),
		.nl        (bp_q[3'(REG_ERR_NL)]),
		.ns        (bp_q[3'(REG_ERR_NS)]),
		.ps        (bp_q[3'(REG_ERR_PS)]),
		.pl        (bp_q[3'(REG_ERR_PL)]),
		.out_valid (err_vld),
		.memb      (me)
	);

	figs_fuzz #(.F(F)) u_fuzz_chg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.x         (item.err_change),
		.nl        (bp_q[3'(REG_CHG_NL)]),
		.ns        (bp_q[3'(REG_CHG_NS)]),
		.ps        (bp_q[3'(REG_CHG_PS)]),
		.pl        (bp_q[3'(REG_CHG_PL)]),
		.out_valid (chg_vld),
		.memb      (mc)
	);

	figs_rule_agg #(.F(F)) u_rule_agg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (err_vld),
		.me        (me),
		.mc        (mc),
		.out_valid (agg_vld),
		.dividend  (dividend),
		.den       (den),
		.den_zero  (den_zero)
	);

	figs_wavg_div #(.F(F)) u_wavg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (agg_vld),
		.dividend  (dividend),
		.den       (den),
		.den_zero  (den_zero),
		.out_valid (done),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		err_vld == chg_vld)
		else $error("fuzzifier lanes out of step");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, LAT))
		else $error("result without matching transaction");

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LAT done)
		else $error("transaction lost in pipeline");

	a_no_rule_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.no_rule_fired) |-> (result.ki_gain == '0))
		else $error("gain not forced to zero");
`endif

endmodule

FILE: dv/fuzzy_integral_gain_scheduler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_integral_gain_scheduler_core_test
// Self-checking bench for the fuzzy integral gain scheduler. A local model
// fuzzifies error and error change, applies the 5x5 min/max rule base and
// the weighted average, and each result is compared in order against it.
// Breakpoints are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module fuzzy_integral_gain_scheduler_core_test;
	import figs_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = FRAC + 20;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ONE = 64'sd1 <<< FRAC;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	figs_in_t item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BP_W-1:0] cfg_data = '0;
	logic done;
	figs_out_t result;

	fuzzy_integral_gain_scheduler_core #(.MEMB_FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	figs_in_t pending_items[$];
	figs_out_t expected_gains[$];
	longint breakpoints[8];
	int send_idle_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	function automatic longint tri_memb(longint x, longint lo, longint pk, longint hi);
		if (x == pk) return ONE;
		if (x < pk) begin
			if (x <= lo) return 0;
			return ((x - lo) <<< FRAC) / (pk - lo);
		end
		if (x >= hi) return 0;
		return ((hi - x) <<< FRAC) / (hi - pk);
	endfunction

	task automatic fuzzify(input longint x, input int base, output longint m[5]);
		longint nl, ns, ps, pl;
		nl = breakpoints[base]; ns = breakpoints[base+1];
		ps = breakpoints[base+2]; pl = breakpoints[base+3];
		foreach (m[k]) m[k] = 0;
		if (x <= nl) begin
			m[0] = ONE;
		end else if (x <= pl) begin
			m[0] = tri_memb(x, nl - SHOULDER_SPAN, nl, ns);
			m[1] = tri_memb(x, nl, ns, 0);
			m[2] = tri_memb(x, ns, 0, ps);
			m[3] = tri_memb(x, 0, ps, pl);
			m[4] = tri_memb(x, ps, pl, pl + SHOULDER_SPAN);
		end else begin
			m[4] = ONE;
		end
	endtask

	task automatic predict_gain(input figs_in_t it);
		longint me[5], mc[5], agg[4], s, num, den;
		longint weights[4];
		int cls;
		figs_out_t r;
		weights = '{longint'(W_PM), longint'(W_PMS), longint'(W_PS), longint'(W_PVS)};
		agg = '{0, 0, 0, 0};
		fuzzify(longint'(it.err_value), 0, me);
		fuzzify(longint'(it.err_change), 4, mc);
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++) begin
				s = me[i] < mc[j] ? me[i] : mc[j];
				if (i == 0 || i == 4) cls = 0;
				else if (i == 1 || i == 3) cls = 1;
				else cls = (j == 2) ? 3 : 2;
				if (s > agg[cls]) agg[cls] = s;
			end
		num = 0; den = 0;
		for (int k = 0; k < 4; k++) begin
			num += agg[k] * weights[k];
			den += agg[k];
		end
		if (den == 0) begin
			r.ki_gain = '0;
			r.no_rule_fired = 1'b1;
		end else begin
			r.ki_gain = GAIN_W'((num + den / 2) / den);
			r.no_rule_fired = 1'b0;
		end
		expected_gains.push_back(r);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n || pending_items.size() == 0) begin
			start <= 1'b0;
		end else if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			item <= pending_items[0];
		end
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			predict_gain(item);
			void'(pending_items.pop_front());
		end
	end

	// monitor
	always @(posedge clk) begin
		figs_out_t exp_r;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_gains.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result ki_gain=%0d flag=%0b", result.ki_gain,
						result.no_rule_fired);
			end else begin
				exp_r = expected_gains.pop_front();
				if (exp_r.ki_gain !== result.ki_gain ||
					exp_r.no_rule_fired !== result.no_rule_fired) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ki_gain=%0d flag=%0b, got ki_gain=%0d flag=%0b",
							exp_r.ki_gain, exp_r.no_rule_fired, result.ki_gain,
							result.no_rule_fired);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("fuzzy_integral_gain_scheduler_core_test: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= BP_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		breakpoints[3'(idx)] = longint'($signed(BP_W'(val)));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_bad_index();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(8 + $urandom_range(7));
		cfg_data <= BP_W'($urandom);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_gains.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_set(input longint enl, ens, eps, epl, cnl, cns, cps, cpl);
		write_reg(REG_ERR_NL, enl); write_reg(REG_ERR_NS, ens);
		write_reg(REG_ERR_PS, eps); write_reg(REG_ERR_PL, epl);
		write_reg(REG_CHG_NL, cnl); write_reg(REG_CHG_NS, cns);
		write_reg(REG_CHG_PS, cps); write_reg(REG_CHG_PL, cpl);
	endtask

	function automatic logic signed [BP_W-1:0] near_bp(input int base);
		int sel;
		sel = $urandom_range(5);
		if (sel == 5) return $signed(BP_W'($urandom));
		if (sel == 4) return BP_W'(0) + BP_W'($urandom_range(200) - 100);
		return BP_W'(breakpoints[base + sel] + $urandom_range(60000) - 30000);
	endfunction

	task automatic add_random(input int n);
		figs_in_t it;
		repeat (n) begin
			it.err_value = near_bp(0);
			it.err_change = near_bp(4);
			pending_items.push_back(it);
		end
	endtask

	task automatic add_item(input longint e, input longint c);
		figs_in_t it;
		it.err_value = BP_W'(e);
		it.err_change = BP_W'(c);
		pending_items.push_back(it);
	endtask

	initial begin
		breakpoints = '{-51200, -25600, 25600, 51200, -51200, -25600, 25600, 51200};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, peaks, feet, shoulders
		send_idle_pct = 26;
		add_item(-8388608, -8388608); add_item(8388607, 8388607);
		add_item(-8388608, 8388607); add_item(0, 0);
		add_item(-51200, -25600); add_item(25600, 51200);
		add_item(-51199, 51201); add_item(-25600, 0);
		add_item(12800, -12800); add_item(51200, 51199);
		add_item(-76800, 76800); add_item(-1, 1);
		add_item(38400, -38400); add_item(-8388607, 8388606);
		drain();

		// misordered breakpoints and zero-sum cases
		load_set(51200, 25600, -25600, -51200, 100, 100, 100, 100);
		write_bad_index();
		add_item(0, 0); add_item(100, 100); add_item(-30000, 50);
		add_item(30000, 101); add_item(60000, -60000); add_item(0, 8388607);
		add_random(80);
		drain();

		// extreme breakpoints
		load_set(-8388608, -8388608, 8388607, 8388607,
			-8388608, -100, 100, 8388607);
		add_item(-8388608, -8388608); add_item(8388607, 8388607);
		add_random(100);
		drain();

		send_idle_pct = 50;
		load_set(-1000, -500, 500, 1000, -300000, -2000, 70000, 300000);
		add_random(150);
		drain();

		send_idle_pct = 0;
		load_set(-51200, -25600, 25600, 51200, -51200, -25600, 25600, 51200);
		add_random(150);
		drain();

		if (mismatches == 0)
			$display("fuzzy_integral_gain_scheduler_core_test: PASS");
		else
			$display("fuzzy_integral_gain_scheduler_core_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/figs_pkg.sv
rtl/figs_fuzz.sv
rtl/figs_rule_agg.sv
rtl/figs_wavg_div.sv
rtl/fuzzy_integral_gain_scheduler_core.sv
dv/fuzzy_integral_gain_scheduler_core_test.sv
